// ----- rtl/bnms_pkg.sv -----
package bnms_pkg;

   localparam int MAX_BOXES_DEF   = 64;
   localparam int MAX_BOXES_LIMIT = 64;
   localparam int COORD_BITS_DEF  = 16;

   localparam int CNT_W      = $clog2(MAX_BOXES_LIMIT + 1);
   localparam int KEPT_IDX_W = 6;

   localparam int                THR_W         = 17;
   localparam logic [THR_W-1:0]  THR_RESET     = 17'd29491;
   localparam int                IOU_ONE_SHIFT = 16;

   // descriptor queue depth, one box bank per slot
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int                 CSR_ADDR_W        = 3;
   localparam int                 CSR_DATA_W        = 32;
   localparam int                 CSR_IDX_W         = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_THRESHOLD = 1'b0;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             overflow;
   } desc_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QPTR_W-1:0] wr_bank;
      logic [QPTR_W-1:0] rd_bank;
   } q_status_type;

endpackage

// ----- rtl/bnms_req_if.sv -----
interface bnms_req_if import bnms_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] box_cx;
   logic [COORD_BITS-1:0] box_cy;
   logic [COORD_BITS-1:0] box_w;
   logic [COORD_BITS-1:0] box_h;
   logic                  last_box;

   modport source (output valid, box_cx, box_cy, box_w, box_h, last_box, input ready);
   modport sink   (input valid, box_cx, box_cy, box_w, box_h, last_box, output ready);
endinterface

// ----- rtl/bnms_rsp_if.sv -----
interface bnms_rsp_if import bnms_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [KEPT_IDX_W-1:0] kept_index;
   logic                  last_kept;
   logic                  overflow;

   modport source (output valid, kept_index, last_kept, overflow, input ready);
   modport sink   (input valid, kept_index, last_kept, overflow, output ready);
endinterface

// ----- rtl/greedy_box_nms_top.sv -----
// channel  | direction | fields                                     | accepted when
// ---------+-----------+--------------------------------------------+---------------------
// req_if   | in        | box_cx, box_cy, box_w, box_h, last_box     | valid && ready
// rsp_if   | out       | kept_index, last_kept, overflow            | valid && ready
// csr_*    | in (APB)  | 0x0: iou_threshold[16:0], reset 29491      | psel&penable&pwrite
//
// Boxes load at one item per cycle into one of two box banks; a closed set waits in a
// two-slot queue while the next set loads, so req stalls only while both banks are held.
// Pass for n boxes: each unsuppressed box i < n-1 runs setup, compares against boxes i+1..n-1
// and a six-stage drain; other rows are skipped. Emit then walks the indices up to the last kept,
// then the set retires. Sync reset clears control state and the threshold.
// Box banks are not cleared. A stalled rsp holds its item; the pass waits only while emitting.
module greedy_box_nms_top import bnms_pkg::*; #(
   parameter  int MAX_BOXES  = MAX_BOXES_DEF,
   parameter  int COORD_BITS = COORD_BITS_DEF,
   localparam int IW         = $clog2(MAX_BOXES),
   localparam int AW         = QPTR_W + IW,
   localparam int BW         = 4 * COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   bnms_req_if.sink              req_if,
   bnms_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             csr_wr;

   q_status_type  q_status;
   desc_type      q_head;
   desc_type      push_desc;
   logic          push;
   logic          q_pop;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [BW-1:0] mem_wr_data;

   always_comb begin
      csr_pready = 1'b1;
      csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_THRESHOLD);
      thr_in     = csr_wr ? csr_pwdata[THR_W-1:0] : thr_ff;
      csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_THRESHOLD) ?
                   CSR_DATA_W'(thr_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   bnms_front #(
      .MAX_BOXES  (MAX_BOXES),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .req_box_cx   (req_if.box_cx),
      .req_box_cy   (req_if.box_cy),
      .req_box_w    (req_if.box_w),
      .req_box_h    (req_if.box_h),
      .req_last_box (req_if.last_box),
      .q_status     (q_status),
      .push         (push),
      .push_desc    (push_desc),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   bnms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .status    (q_status),
      .head      (q_head)
   );

   bnms_engine #(
      .MAX_BOXES  (MAX_BOXES),
      .COORD_BITS (COORD_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .q_status       (q_status),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .threshold      (thr_ff),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_kept_index (rsp_if.kept_index),
      .rsp_last_kept  (rsp_if.last_kept),
      .rsp_overflow   (rsp_if.overflow)
   );

endmodule

// ----- rtl/bnms_queue.sv -----
module bnms_queue import bnms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  desc_type     push_desc,
   input  logic         pop,
   output q_status_type status,
   output desc_type     head
);

   desc_type          slot_ff [QUEUE_DEPTH];
   desc_type          slot_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      slot_in   = push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   assign status.full    = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty   = (fill_ff == '0);
   assign status.wr_bank = wr_ptr_ff;
   assign status.rd_bank = rd_ptr_ff;
   assign head           = slot_ff[rd_ptr_ff];

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push || pop)
      else $error("queue push while full");
   a_no_underrun : assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("queue pop while empty");
   a_fill_tracks_ptrs : assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == (QPTR_W+1)'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill");

endmodule

// ----- rtl/bnms_front.sv -----
module bnms_front import bnms_pkg::*; #(
   parameter  int MAX_BOXES  = MAX_BOXES_DEF,
   parameter  int COORD_BITS = COORD_BITS_DEF,
   localparam int IW         = $clog2(MAX_BOXES),
   localparam int CW         = $clog2(MAX_BOXES + 1),
   localparam int AW         = QPTR_W + IW,
   localparam int BW         = 4 * COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_box_cx,
   input  logic [COORD_BITS-1:0] req_box_cy,
   input  logic [COORD_BITS-1:0] req_box_w,
   input  logic [COORD_BITS-1:0] req_box_h,
   input  logic                  req_last_box,
   input  q_status_type          q_status,
   output logic                  push,
   output desc_type              push_desc,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [BW-1:0]         mem_wr_data
);

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          accept;
   logic          room;
   logic [CW-1:0] count_new;
   logic          ovf_new;

   always_comb begin
      req_ready   = !q_status.full;
      accept      = req_valid && req_ready;
      room        = (count_ff < CW'(MAX_BOXES));
      mem_wr_en   = accept && room;
      mem_wr_addr = {q_status.wr_bank, count_ff[IW-1:0]};
      mem_wr_data = {req_box_cx, req_box_cy, req_box_w, req_box_h};
      count_new   = count_ff + CW'(mem_wr_en);
      ovf_new     = ovf_ff || (accept && !room);
      push        = accept && req_last_box;
      push_desc.count    = CNT_W'(count_new);
      push_desc.overflow = ovf_new;
      count_in    = push ? '0 : count_new;
      ovf_in      = push ? 1'b0 : ovf_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   a_wr_in_range : assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> count_ff < CW'(MAX_BOXES))
      else $error("box written beyond capacity");
   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("set closed into a full queue");
   a_count_restarts : assert property (@(posedge clock) disable iff (reset)
      push |=> count_ff == '0 && !ovf_ff)
      else $error("set state not cleared after last box");

endmodule

// ----- rtl/bnms_iou.sv -----
module bnms_iou import bnms_pkg::*; #(
   parameter  int COORD_BITS = COORD_BITS_DEF,
   parameter  int IDX_W      = 6,
   localparam int C          = COORD_BITS,
   localparam int BW         = 4 * C
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [IDX_W-1:0] in_idx,
   input  logic [BW-1:0]    box_a,
   input  logic [BW-1:0]    box_b,
   input  logic [THR_W-1:0] threshold,
   output logic             out_valid,
   output logic [IDX_W-1:0] out_idx,
   output logic             out_hit,
   output logic             busy
);

   localparam int EW   = C + 3;
   localparam int DW   = C + 1;
   localparam int AREW = 2 * C;
   localparam int IW4  = 2 * C + 2;
   localparam int UW   = 2 * C + 3;
   localparam int PW   = UW + THR_W;
   localparam int LW   = IW4 + IOU_ONE_SHIFT;
   localparam int CMPW = (PW > LW) ? PW : LW;
   localparam int NST  = 6;

   logic [NST-1:0]   vld_ff, vld_in;
   logic [IDX_W-1:0] idx_ff [NST];

   logic [C-1:0] a_cx, a_cy, a_w, a_h, b_cx, b_cy, b_w, b_h;
   logic signed [EW-1:0] alx, arx, aly, ary, blx, brx, bly, bry;

   // stage 1: edges and box areas
   logic signed [EW-1:0] lx_ff, rx_ff, ly_ff, ry_ff, lx_in, rx_in, ly_in, ry_in;
   logic [AREW-1:0]      area_a_ff, area_b_ff, area_a_in, area_b_in;
   // stage 2: overlaps and area sum
   logic signed [EW:0]   dx, dy;
   logic [DW-1:0]        ow_ff, oh_ff, ow_in, oh_in;
   logic [AREW:0]        asum_ff, asum_in;
   // stage 3: intersection and area sum, x4
   logic [IW4-1:0]       inter3_ff, inter3_in;
   logic [UW-1:0]        area4_ff, area4_in;
   // stage 4: union
   logic [UW-1:0]        uni_ff, uni_in;
   logic [IW4-1:0]       inter4_ff;
   logic                 gate4_ff, gate4_in;
   // stage 5: threshold product
   logic [PW-1:0]        prod_ff, prod_in;
   logic [IW4-1:0]       inter5_ff;
   logic                 gate5_ff;
   // stage 6: decision
   logic                 hit_ff, hit_in;

   always_comb begin
      {a_cx, a_cy, a_w, a_h} = box_a;
      {b_cx, b_cy, b_w, b_h} = box_b;
      alx = $signed({2'b00, a_cx, 1'b0}) - $signed({3'b000, a_w});
      arx = $signed({2'b00, a_cx, 1'b0}) + $signed({3'b000, a_w});
      aly = $signed({2'b00, a_cy, 1'b0}) - $signed({3'b000, a_h});
      ary = $signed({2'b00, a_cy, 1'b0}) + $signed({3'b000, a_h});
      blx = $signed({2'b00, b_cx, 1'b0}) - $signed({3'b000, b_w});
      brx = $signed({2'b00, b_cx, 1'b0}) + $signed({3'b000, b_w});
      bly = $signed({2'b00, b_cy, 1'b0}) - $signed({3'b000, b_h});
      bry = $signed({2'b00, b_cy, 1'b0}) + $signed({3'b000, b_h});
      lx_in = (alx > blx) ? alx : blx;
      rx_in = (arx < brx) ? arx : brx;
      ly_in = (aly > bly) ? aly : bly;
      ry_in = (ary < bry) ? ary : bry;
      area_a_in = a_w * a_h;
      area_b_in = b_w * b_h;

      dx = $signed({rx_ff[EW-1], rx_ff}) - $signed({lx_ff[EW-1], lx_ff});
      dy = $signed({ry_ff[EW-1], ry_ff}) - $signed({ly_ff[EW-1], ly_ff});
      ow_in = dx[EW] ? '0 : dx[DW-1:0];
      oh_in = dy[EW] ? '0 : dy[DW-1:0];
      asum_in = {1'b0, area_a_ff} + {1'b0, area_b_ff};

      inter3_in = ow_ff * oh_ff;
      area4_in  = {asum_ff, 2'b00};

      gate4_in = (UW'(inter3_ff) >= area4_ff);
      uni_in   = area4_ff - UW'(inter3_ff);

      prod_in = PW'(threshold) * PW'(uni_ff);

      hit_in = !gate5_ff &&
               (CMPW'({inter5_ff, {IOU_ONE_SHIFT{1'b0}}}) >= CMPW'(prod_ff));

      vld_in = {vld_ff[NST-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      idx_ff[0] <= in_idx;
      for (int s = 1; s < NST; s++) begin
         idx_ff[s] <= idx_ff[s-1];
      end
      lx_ff     <= lx_in;
      rx_ff     <= rx_in;
      ly_ff     <= ly_in;
      ry_ff     <= ry_in;
      area_a_ff <= area_a_in;
      area_b_ff <= area_b_in;
      ow_ff     <= ow_in;
      oh_ff     <= oh_in;
      asum_ff   <= asum_in;
      inter3_ff <= inter3_in;
      area4_ff  <= area4_in;
      uni_ff    <= uni_in;
      inter4_ff <= inter3_ff;
      gate4_ff  <= gate4_in;
      prod_ff   <= prod_in;
      inter5_ff <= inter4_ff;
      gate5_ff  <= gate4_ff;
      hit_ff    <= hit_in;
   end

   assign out_valid = vld_ff[NST-1];
   assign out_idx   = idx_ff[NST-1];
   assign out_hit   = hit_ff;
   assign busy      = |vld_ff;

endmodule

// ----- rtl/bnms_engine.sv -----
module bnms_engine import bnms_pkg::*; #(
   parameter  int MAX_BOXES  = MAX_BOXES_DEF,
   parameter  int COORD_BITS = COORD_BITS_DEF,
   localparam int IW         = $clog2(MAX_BOXES),
   localparam int CW         = $clog2(MAX_BOXES + 1),
   localparam int AW         = QPTR_W + IW,
   localparam int BW         = 4 * COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mem_wr_en,
   input  logic [AW-1:0]         mem_wr_addr,
   input  logic [BW-1:0]         mem_wr_data,
   input  q_status_type          q_status,
   input  desc_type              q_head,
   output logic                  q_pop,
   input  logic [THR_W-1:0]      threshold,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KEPT_IDX_W-1:0] rsp_kept_index,
   output logic                  rsp_last_kept,
   output logic                  rsp_overflow
);

   localparam int MEM_DEPTH = QUEUE_DEPTH * (2 ** IW);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROW, ST_LOAD, ST_SCAN, ST_DRAIN, ST_EMIT
   } state_type;

   logic [BW-1:0] mem [MEM_DEPTH];
   logic [BW-1:0] rd_data_ff;
   logic [IW-1:0] rd_idx;

   state_type              state_ff, state_in;
   logic [CW-1:0]          i_ff, i_in;
   logic [IW-1:0]          j_ff, j_in;
   logic [IW-1:0]          k_ff, k_in;
   logic [MAX_BOXES-1:0]   mask_ff, mask_in;
   logic [MAX_BOXES-1:0]   alive_ff, alive_in;
   logic [MAX_BOXES-1:0]   alive_vec;
   logic [MAX_BOXES-1:0]   kbit;
   logic [BW-1:0]          box_a_ff, box_a_in;
   logic                   issue_ff, issue_in;
   logic [IW-1:0]          issue_idx_ff, issue_idx_in;
   logic                   out_vld_ff, out_vld_in;
   logic [KEPT_IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_ovf_ff, out_ovf_in;
   logic                   out_free;
   logic [CW-1:0]          n;

   logic          hit_valid;
   logic [IW-1:0] hit_idx;
   logic          hit;
   logic          busy;

   bnms_iou #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IW)
   ) u_iou (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue_ff),
      .in_idx    (issue_idx_ff),
      .box_a     (box_a_ff),
      .box_b     (rd_data_ff),
      .threshold (threshold),
      .out_valid (hit_valid),
      .out_idx   (hit_idx),
      .out_hit   (hit),
      .busy      (busy)
   );

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= mem[{q_status.rd_bank, rd_idx}];
   end

   always_comb begin
      n = q_head.count[CW-1:0];
      for (int b = 0; b < MAX_BOXES; b++) begin
         alive_vec[b] = !mask_ff[b] && (CW'(b) < n);
      end
      kbit     = MAX_BOXES'(1) << k_ff;
      out_free = !out_vld_ff || rsp_ready;

      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      mask_in      = mask_ff;
      alive_in     = alive_ff;
      box_a_in     = box_a_ff;
      issue_in     = 1'b0;
      issue_idx_in = j_ff;
      out_vld_in   = out_vld_ff && !rsp_ready;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      q_pop        = 1'b0;
      rd_idx       = i_ff[IW-1:0];

      if (hit_valid && hit) begin
         mask_in[hit_idx] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               i_in     = '0;
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            if (i_ff >= n) begin
               alive_in = alive_vec;
               k_in     = '0;
               state_in = ST_EMIT;
            end else if (mask_ff[i_ff[IW-1:0]] || ((i_ff + CW'(1)) >= n)) begin
               i_in = i_ff + CW'(1);
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            box_a_in = rd_data_ff;
            j_in     = i_ff[IW-1:0] + IW'(1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_idx   = j_ff;
            issue_in = 1'b1;
            if ((CW'(j_ff) + CW'(1)) == n) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            if (!issue_ff && !busy) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_ROW;
            end
         end
         ST_EMIT: begin
            if (alive_ff == '0) begin
               q_pop    = 1'b1;
               mask_in  = '0;
               state_in = ST_IDLE;
            end else if (alive_ff[k_ff]) begin
               if (out_free) begin
                  out_vld_in  = 1'b1;
                  out_idx_in  = KEPT_IDX_W'(k_ff);
                  out_last_in = ((alive_ff & ~kbit) == '0);
                  out_ovf_in  = q_head.overflow;
                  alive_in    = alive_ff & ~kbit;
                  k_in        = k_ff + IW'(1);
               end
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mask_ff    <= '0;
         alive_ff   <= '0;
         issue_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mask_ff    <= mask_in;
         alive_ff   <= alive_in;
         issue_ff   <= issue_in;
         out_vld_ff <= out_vld_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      box_a_ff     <= box_a_in;
      issue_idx_ff <= issue_idx_in;
      out_idx_ff   <= out_idx_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_kept_index = out_idx_ff;
   assign rsp_last_kept  = out_last_ff;
   assign rsp_overflow   = out_ovf_ff;

   a_hits_in_pass : assert property (@(posedge clock) disable iff (reset)
      hit_valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("compare result outside suppression pass");
   a_row_starts_drained : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> !busy && !issue_ff)
      else $error("new row started with compares in flight");
   a_mask_frozen_in_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && $past(state_ff == ST_EMIT)) |-> $stable(mask_ff))
      else $error("suppression mask changed while emitting");
   a_pop_has_set : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("set retired with none queued");

endmodule
